// File: hdl/skf_pkg.sv
package skf_pkg;

	// field widths fixed by the item format
	localparam int WEIGHT_W = 20;
	localparam int TOL_W    = 12;
	localparam int DIM_W    = 5;
	localparam int FIDX_W   = 3;
	localparam int Q_ONE    = 4096;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd2;

	localparam logic signed [WEIGHT_W-1:0] F_MAX = 20'sh7FFFF;
	localparam logic signed [WEIGHT_W-1:0] F_MIN = 20'sh80000;

	typedef logic signed [WEIGHT_W-1:0] weight_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [TOL_W-1:0] tol;
	} cfg_t;

	// front to back: a full kernel sits in the store
	typedef struct packed {
		logic valid;
	} job_t;

	// back to front
	typedef struct packed {
		logic take;
		logic busy;
	} back_stat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SCAN_RD,
		B_SCAN_CHK,
		B_ROW_RD,
		B_ROW_WR,
		B_COL_RD,
		B_COL_DIV,
		B_DIV,
		B_CHK_RD,
		B_CHK_MUL,
		B_CHK_CMP,
		B_EMIT
	} back_state_t;

	function automatic logic [WEIGHT_W-1:0] mag20(input logic signed [WEIGHT_W-1:0] v);
		logic [WEIGHT_W-1:0] u;
		u = v;
		return v[WEIGHT_W-1] ? (~u + 1'b1) : u;
	endfunction

endpackage

// File: hdl/skf_in_if.sv
interface skf_in_if;
	logic                     valid;
	logic                     ready;
	logic signed [19:0]       weight;

	modport source (output valid, output weight, input ready);
	modport sink   (input valid, input weight, output ready);
endinterface

// File: hdl/skf_out_if.sv
interface skf_out_if;
	logic                     valid;
	logic                     ready;
	logic                     separable;
	logic                     which_factor;
	logic [2:0]               factor_index;
	logic signed [19:0]       factor_value;
	logic                     last;

	modport source (output valid, output separable, output which_factor,
		output factor_index, output factor_value, output last, input ready);
	modport sink   (input valid, input separable, input which_factor,
		input factor_index, input factor_value, input last, output ready);
endinterface

// File: hdl/skf_ram.sv
module skf_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/skf_front.sv
module skf_front #(
	parameter int MAX_DIM = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	skf_in_if.sink               in_ch,
	input  skf_pkg::cfg_t        cfg,
	input  logic                 cfg_clr,
	input  skf_pkg::back_stat_t  bstat,
	output skf_pkg::job_t        job,
	output logic                 we,
	output logic [(MAX_DIM*MAX_DIM>1?$clog2(MAX_DIM*MAX_DIM):1)-1:0] waddr,
	output logic [skf_pkg::WEIGHT_W-1:0] wdata
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          pend_q;
	logic [CW-1:0] total;
	logic          acc;

	assign total = CW'(cfg.width * cfg.height);
	assign in_ch.ready = !pend_q && !bstat.busy;
	assign acc = in_ch.valid && in_ch.ready;

	assign we    = acc;
	assign waddr = count_q[AW-1:0];
	assign wdata = in_ch.weight;
	assign job.valid = pend_q;

	// load counter and one-deep job queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (bstat.take) begin
				pend_q <= 1'b0;
			end
			if (cfg_clr) begin
				count_q <= '0;
			end else if (acc) begin
				if (count_q + 1'b1 == total) begin
					count_q <= '0;
					pend_q  <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end
endmodule

// File: hdl/skf_back.sv
module skf_back #(
	parameter int MAX_DIM = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  skf_pkg::cfg_t        cfg,
	input  skf_pkg::job_t        job,
	output skf_pkg::back_stat_t  bstat,
	output logic [(MAX_DIM*MAX_DIM>1?$clog2(MAX_DIM*MAX_DIM):1)-1:0] raddr,
	input  logic [skf_pkg::WEIGHT_W-1:0] rdata,
	skf_out_if.source            out_ch
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int WW = skf_pkg::WEIGHT_W;
	localparam int DW = skf_pkg::DIM_W;
	localparam int QW = 33;
	localparam int QCW = $clog2(QW + 1);

	skf_pkg::back_state_t st_q, st_d;

	logic [AW-1:0]            ptr_q;
	logic [DW-1:0]            row_q, col_q, px_q;
	logic signed [WW-1:0]     pivot_q;
	skf_pkg::weight_t         hz_q [MAX_DIM];
	skf_pkg::weight_t         vf_q [MAX_DIM];
	logic                     sep_q, which_q;
	logic [DW-1:0]            eidx_q;
	// divider
	logic [QW-1:0]            num_q, quo_q;
	logic [WW+1:0]            rem_q;
	logic [WW:0]              den_q;
	logic                     neg_q;
	logic [QCW-1:0]           bit_q;
	// match test
	logic signed [2*WW-1:0]   prod_q;
	logic [31:0]              lim_q;
	logic signed [WW-1:0]     a_q;

	logic [CW-1:0]            total;
	logic                     ptr_last;
	logic                     col_last, row_last;
	skf_pkg::weight_t         a_in;
	logic [WW-1:0]            a_mag, p_mag;
	logic [RW-1:0]            vidx;
	logic [WW+1:0]            rem_sh;
	logic                     rem_ge;
	logic [QW-1:0]            quo_nx;
	skf_pkg::weight_t         div_res;
	logic signed [2*WW:0]     diff;
	logic [2*WW:0]            diff_mag;
	logic                     emit_last;
	logic [31:0]              num_init;

	assign total    = CW'(cfg.width * cfg.height);
	assign ptr_last = (CW'(ptr_q) == total - 1'b1);
	assign col_last = (col_q == cfg.width - 1'b1);
	assign row_last = (row_q == cfg.height - 1'b1);
	assign a_in     = rdata;
	assign a_mag    = skf_pkg::mag20(a_in);
	assign p_mag    = skf_pkg::mag20(pivot_q);
	assign vidx     = (st_q == skf_pkg::B_EMIT) ? eidx_q[RW-1:0] : row_q[RW-1:0];
	assign num_init = {a_mag, 12'b0};

	// restoring divider step
	assign rem_sh = {rem_q[WW:0], num_q[QW-1]};
	assign rem_ge = (rem_sh >= {1'b0, den_q});
	assign quo_nx = {quo_q[QW-2:0], rem_ge};

	// sign and saturation of the finished quotient
	always_comb begin
		if (neg_q) begin
			div_res = (quo_nx > QW'(524288)) ? skf_pkg::F_MIN : WW'(~quo_nx[WW-1:0] + 1'b1);
		end else begin
			div_res = (quo_nx > QW'(524287)) ? skf_pkg::F_MAX : quo_nx[WW-1:0];
		end
	end

	// factor product error
	assign diff     = (2*WW+1)'($signed({a_q, 12'b0})) - (2*WW+1)'(prod_q);
	assign diff_mag = diff[2*WW] ? (~diff + 1'b1) : diff;

	assign emit_last = !sep_q || (which_q && eidx_q == cfg.width - 1'b1);

	// output payload from held registers
	assign out_ch.valid        = (st_q == skf_pkg::B_EMIT);
	assign out_ch.separable    = sep_q;
	assign out_ch.which_factor = sep_q && which_q;
	assign out_ch.factor_index = sep_q ? eidx_q[2:0] : 3'd0;
	assign out_ch.factor_value = !sep_q ? '0 : (which_q ? hz_q[vidx] : vf_q[vidx]);
	assign out_ch.last         = emit_last;

	assign bstat.take = (st_q == skf_pkg::B_IDLE) && job.valid;
	assign bstat.busy = (st_q != skf_pkg::B_IDLE) && (st_q != skf_pkg::B_EMIT);

	// store read address
	always_comb begin
		raddr = ptr_q;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			skf_pkg::B_IDLE:     if (job.valid) st_d = skf_pkg::B_SCAN_RD;
			skf_pkg::B_SCAN_RD:  st_d = skf_pkg::B_SCAN_CHK;
			skf_pkg::B_SCAN_CHK: begin
				if (a_mag > WW'(cfg.tol)) st_d = skf_pkg::B_ROW_RD;
				else if (ptr_last) st_d = skf_pkg::B_EMIT;
				else st_d = skf_pkg::B_SCAN_RD;
			end
			skf_pkg::B_ROW_RD:   st_d = skf_pkg::B_ROW_WR;
			skf_pkg::B_ROW_WR:   st_d = col_last ? skf_pkg::B_COL_RD : skf_pkg::B_ROW_RD;
			skf_pkg::B_COL_RD:   st_d = skf_pkg::B_COL_DIV;
			skf_pkg::B_COL_DIV:  st_d = skf_pkg::B_DIV;
			skf_pkg::B_DIV: begin
				if (bit_q == QCW'(1)) st_d = row_last ? skf_pkg::B_CHK_RD : skf_pkg::B_COL_RD;
			end
			skf_pkg::B_CHK_RD:   st_d = skf_pkg::B_CHK_MUL;
			skf_pkg::B_CHK_MUL:  st_d = skf_pkg::B_CHK_CMP;
			skf_pkg::B_CHK_CMP: begin
				if (diff_mag > (2*WW+1)'(lim_q)) st_d = skf_pkg::B_EMIT;
				else if (ptr_last) st_d = skf_pkg::B_EMIT;
				else st_d = skf_pkg::B_CHK_RD;
			end
			skf_pkg::B_EMIT:     if (out_ch.ready && emit_last) st_d = skf_pkg::B_IDLE;
			default:             st_d = skf_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= skf_pkg::B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			skf_pkg::B_IDLE: begin
				ptr_q <= '0;
				col_q <= '0;
				row_q <= '0;
			end
			skf_pkg::B_SCAN_CHK: begin
				if (a_mag > WW'(cfg.tol)) begin
					pivot_q <= a_in;
					px_q    <= col_q;
					ptr_q   <= ptr_q - AW'(col_q);
					col_q   <= '0;
				end else if (ptr_last) begin
					// no pivot: unit column, zero row
					for (int k = 0; k < MAX_DIM; k++) begin
						vf_q[k] <= WW'(skf_pkg::Q_ONE);
						hz_q[k] <= '0;
					end
					sep_q   <= 1'b1;
					which_q <= 1'b0;
					eidx_q  <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
					col_q <= col_last ? '0 : col_q + 1'b1;
				end
			end
			skf_pkg::B_ROW_WR: begin
				hz_q[col_q[RW-1:0]] <= a_in;
				if (col_last) begin
					ptr_q <= AW'(px_q);
					row_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
					col_q <= col_q + 1'b1;
				end
			end
			skf_pkg::B_COL_DIV: begin
				num_q <= {num_init, 1'b0} + QW'(p_mag);
				den_q <= {p_mag, 1'b0};
				rem_q <= '0;
				quo_q <= '0;
				neg_q <= a_in[WW-1] ^ pivot_q[WW-1];
				bit_q <= QCW'(QW);
			end
			skf_pkg::B_DIV: begin
				rem_q <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
				quo_q <= quo_nx;
				num_q <= {num_q[QW-2:0], 1'b0};
				bit_q <= bit_q - 1'b1;
				if (bit_q == QCW'(1)) begin
					vf_q[row_q[RW-1:0]] <= div_res;
					if (row_last) begin
						ptr_q <= '0;
						row_q <= '0;
						col_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						ptr_q <= ptr_q + AW'(cfg.width);
					end
				end
			end
			skf_pkg::B_CHK_MUL: begin
				a_q    <= a_in;
				prod_q <= vf_q[vidx] * hz_q[col_q[RW-1:0]];
				lim_q  <= cfg.tol * (32'(skf_pkg::Q_ONE) + 32'(a_mag));
			end
			skf_pkg::B_CHK_CMP: begin
				sep_q   <= 1'b1;
				which_q <= 1'b0;
				eidx_q  <= '0;
				if (diff_mag > (2*WW+1)'(lim_q)) begin
					sep_q <= 1'b0;
				end else if (!ptr_last) begin
					ptr_q <= ptr_q + 1'b1;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
			skf_pkg::B_EMIT: begin
				if (out_ch.ready && !emit_last) begin
					if (!which_q && eidx_q == cfg.height - 1'b1) begin
						which_q <= 1'b1;
						eidx_q  <= '0;
					end else begin
						eidx_q <= eidx_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// File: hdl/separable_kernel_factorizer_core.sv
// weights are taken one per cycle unless a full kernel waits or the decision pass is busy;
// the last weight of a kernel starts the decision pass: a pivot scan, a pivot-row copy,
// the vertical factor divider per row (one quotient bit a cycle), and the weight check
// results then leave one per cycle while ready is high; the next kernel loads while results drain
// async reset clears control state; registers return to width 3, height 3, tolerance 4
module separable_kernel_factorizer_core #(
	parameter int MAX_DIM = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	skf_in_if.sink                         in_ch,
	skf_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [skf_pkg::CFG_W-1:0]      cfg_data
);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW = skf_pkg::DIM_W;

	skf_pkg::cfg_t       cfg_q;
	skf_pkg::job_t       job;
	skf_pkg::back_stat_t bstat;
	logic                cfg_clr;
	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [skf_pkg::WEIGHT_W-1:0] wdata, rdata;
	logic [DW-1:0]       dim_in;

	// size clamp to 1..MAX_DIM
	always_comb begin
		dim_in = DW'(cfg_data[3:0]);
		if (dim_in == '0) dim_in = DW'(1);
		else if (dim_in > DW'(MAX_DIM)) dim_in = DW'(MAX_DIM);
	end

	assign cfg_clr = cfg_we && (cfg_index == skf_pkg::REG_WIDTH ||
		cfg_index == skf_pkg::REG_HEIGHT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= DW'(3);
			cfg_q.height <= DW'(3);
			cfg_q.tol    <= 12'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				skf_pkg::REG_WIDTH:  cfg_q.width  <= dim_in;
				skf_pkg::REG_HEIGHT: cfg_q.height <= dim_in;
				skf_pkg::REG_TOL:    cfg_q.tol    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	skf_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.cfg_clr(cfg_clr),
		.bstat  (bstat),
		.job    (job),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	skf_ram #(.WIDTH(skf_pkg::WEIGHT_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	skf_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.job    (job),
		.bstat  (bstat),
		.raddr  (raddr),
		.rdata  (rdata),
		.out_ch (out_ch)
	);
endmodule

// File: tb/tb_separable_kernel_factorizer_core.sv
`timescale 1ns / 100ps

module tb_separable_kernel_factorizer_core;

	localparam int MAX_DIM     = 8;
	localparam int DRAIN_WAIT  = 1000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 125;
	localparam int N_DIRECTED  = 27;
	localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_WEIGHT,
		ROW_WEIGHT_1X1
	} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [skf_pkg::CFG_IDX_W-1:0] idx;
		int                  val;
	} stim_row_t;

	typedef struct {
		skf_pkg::weight_t w;
		bit      typed;
	} weight_item_t;

	typedef struct {
		logic    separable;
		logic    which_factor;
		logic [2:0] factor_index;
		skf_pkg::weight_t factor_value;
		logic    last;
	} factor_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [skf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [skf_pkg::CFG_W-1:0] cfg_data;

	skf_in_if  in_ch();
	skf_out_if out_ch();

	separable_kernel_factorizer_core #(.MAX_DIM(MAX_DIM)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow state of the block
	longint kern_mem [MAX_DIM*MAX_DIM];
	int     load_cnt;
	int     kw;
	int     kh;
	int     tol;

	weight_item_t weight_q[$];
	factor_t      factor_q[$];
	int  fail_count;
	int  hold_req;
	bit  no_gaps;
	bit  sending;
	bit  took;
	int  weights_sent;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycle limit
	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic longint absval(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int clamp_dim(input int v);
		if (v < 1) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic longint q12_divide(input longint a, input longint p);
		longint na, dp, q, r;
		na = absval(a) << 12;
		dp = absval(p);
		q = (2 * na + dp) / (2 * dp);
		r = ((a < 0) != (p < 0)) ? -q : q;
		if (r > 524287) r = 524287;
		if (r < -524288) r = -524288;
		return r;
	endfunction

	function automatic void push_factor(input bit sep, input bit which, input int idx,
		input longint val, input bit lst);
		factor_t f;
		f.separable    = sep;
		f.which_factor = which;
		f.factor_index = idx[2:0];
		f.factor_value = val[19:0];
		f.last         = lst;
		factor_q = {factor_q, f};
	endfunction

	// load one weight, factor the kernel when it is complete
	function automatic void factor_kernel(input skf_pkg::weight_t w);
		int total, py, px;
		bit found, sep;
		longint piv, a, diff, lim;
		longint vf [MAX_DIM];
		longint hz [MAX_DIM];
		total = kw * kh;
		if (load_cnt >= total) load_cnt = 0;
		kern_mem[load_cnt] = w;
		load_cnt++;
		if (load_cnt < total) return;
		load_cnt = 0;
		found = 0;
		py = 0;
		px = 0;
		for (int i = 0; i < kh; i++)
			for (int j = 0; j < kw; j++)
				if (!found && absval(kern_mem[i*kw+j]) > tol) begin
					found = 1;
					py = i;
					px = j;
				end
		sep = 1;
		if (!found) begin
			for (int i = 0; i < kh; i++) vf[i] = skf_pkg::Q_ONE;
			for (int j = 0; j < kw; j++) hz[j] = 0;
		end else begin
			piv = kern_mem[py*kw+px];
			for (int j = 0; j < kw; j++) hz[j] = kern_mem[py*kw+j];
			for (int i = 0; i < kh; i++) vf[i] = q12_divide(kern_mem[i*kw+px], piv);
			for (int i = 0; i < kh; i++)
				for (int j = 0; j < kw; j++) begin
					a = kern_mem[i*kw+j];
					diff = a * skf_pkg::Q_ONE - vf[i] * hz[j];
					lim = longint'(tol) * (skf_pkg::Q_ONE + absval(a));
					if (absval(diff) > lim) sep = 0;
				end
		end
		if (!sep) begin
			push_factor(0, 0, 0, 0, 1);
			return;
		end
		for (int i = 0; i < kh; i++) push_factor(1, 0, i, vf[i], 0);
		for (int j = 0; j < kw; j++) push_factor(1, 1, j, hz[j], j == kw - 1);
	endfunction

	// weight sender
	initial begin : weight_driver
		int gap;
		int n_before;
		weight_item_t it;
		in_ch.valid  = 1'b0;
		in_ch.weight = '0;
		sending = 0;
		weights_sent = 0;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (weight_q.size() == 0 || gap > 0) begin
				in_ch.valid <= 1'b0;
				if (gap > 0) gap--;
			end else begin
				sending = 1;
				it = weight_q[0];
				in_ch.valid  <= 1'b1;
				in_ch.weight <= it.w;
				do @(posedge clk); while (!in_ch.ready);
				void'(weight_q.pop_front());
				n_before = factor_q.size();
				factor_kernel(it.w);
				// a one by one kernel whose weight is zero or above the tolerance factors as 1.0 times the weight
				if (it.typed) begin
					while (factor_q.size() > n_before) factor_q.delete(factor_q.size() - 1);
					push_factor(1, 0, 0, skf_pkg::Q_ONE, 0);
					push_factor(1, 1, 0, it.w, 1);
				end
				weights_sent++;
				gap = no_gaps ? 0 : $urandom_range(0, 3);
				sending = 0;
			end
		end
	end

	// result receiver ready
	initial begin : factor_receiver
		int stall;
		out_ch.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (took) begin
				stall = no_gaps ? 0 : $urandom_range(0, 3);
				took = 0;
			end
			if (hold_req > 0) begin
				out_ch.ready <= 1'b0;
				hold_req--;
			end else if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		factor_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			took = 1;
			if (factor_q.size() == 0) begin
				$error("unexpected result item");
				fail_count++;
			end else begin
				e = factor_q.pop_front();
				if (out_ch.separable !== e.separable) begin
					$error("separable: expected %0d actual %0d", e.separable, out_ch.separable);
					fail_count++;
				end
				if (out_ch.which_factor !== e.which_factor) begin
					$error("which_factor: expected %0d actual %0d", e.which_factor,
						out_ch.which_factor);
					fail_count++;
				end
				if (out_ch.factor_index !== e.factor_index) begin
					$error("factor_index: expected %0d actual %0d", e.factor_index,
						out_ch.factor_index);
					fail_count++;
				end
				if (out_ch.factor_value !== e.factor_value) begin
					$error("factor_value: expected %0d actual %0d", e.factor_value,
						out_ch.factor_value);
					fail_count++;
				end
				if (out_ch.last !== e.last) begin
					$error("last: expected %0d actual %0d", e.last, out_ch.last);
					fail_count++;
				end
			end
		end
	end

	// wait until the block has no work left
	task automatic wait_drained();
		while (weight_q.size() != 0 || sending) @(negedge clk);
		while (factor_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[skf_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			skf_pkg::REG_WIDTH: begin
				kw = clamp_dim(val & 15);
				load_cnt = 0;
			end
			skf_pkg::REG_HEIGHT: begin
				kh = clamp_dim(val & 15);
				load_cnt = 0;
			end
			skf_pkg::REG_TOL: tol = val & 4095;
			default: ;
		endcase
	endtask

	task automatic send_weight(input int v, input bit typed);
		weight_item_t it;
		it.w = v[19:0];
		it.typed = typed;
		weight_q = {weight_q, it};
	endtask

	function automatic int rand_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return MAX_DIM;
		if (r == 1) return $urandom_range(0, 15);
		return $urandom_range(1, 4);
	endfunction

	// one random kernel of the current size
	task automatic send_random_kernel();
		int mode, c, r;
		int col [MAX_DIM];
		int row [MAX_DIM];
		mode = $urandom_range(0, 9);
		for (int i = 0; i < kh; i++) col[i] = $urandom_range(0, 16383) - 8192;
		for (int j = 0; j < kw; j++) row[j] = $urandom_range(0, 16383) - 8192;
		for (int i = 0; i < kh; i++)
			for (int j = 0; j < kw; j++) begin
				if (mode < 6) begin
					c = (col[i] * row[j]) >>> 12;
				end else if (mode == 6) begin
					c = ((col[i] * row[j]) >>> 12) + $urandom_range(0, 64) - 32;
				end else if (mode == 7) begin
					c = $urandom_range(0, 2 * tol) - tol;
				end else begin
					r = $urandom();
					c = r;
				end
				send_weight(c, 0);
			end
	endtask

	stim_row_t directed [N_DIRECTED] = '{
		'{ROW_CFG, skf_pkg::REG_WIDTH, 0},
		'{ROW_CFG, skf_pkg::REG_HEIGHT, 1},
		'{ROW_WEIGHT_1X1, 0, 524287},
		'{ROW_WEIGHT_1X1, 0, -524288},
		'{ROW_WEIGHT_1X1, 0, 0},
		'{ROW_CFG, skf_pkg::REG_TOL, 0},
		'{ROW_WEIGHT_1X1, 0, 1},
		'{ROW_CFG, skf_pkg::REG_TOL, 4095},
		'{ROW_CFG, skf_pkg::REG_WIDTH, 2},
		'{ROW_CFG, skf_pkg::REG_HEIGHT, 2},
		'{ROW_WEIGHT, 0, 4095},
		'{ROW_WEIGHT, 0, -4095},
		'{ROW_WEIGHT, 0, 4095},
		'{ROW_WEIGHT, 0, 100},
		'{ROW_CFG, skf_pkg::REG_TOL, 4},
		'{ROW_WEIGHT, 0, 4096},
		'{ROW_WEIGHT, 0, 0},
		'{ROW_WEIGHT, 0, 0},
		'{ROW_WEIGHT, 0, 4096},
		'{ROW_WEIGHT, 0, 4096},
		'{ROW_WEIGHT, 0, 8192},
		'{ROW_CFG, skf_pkg::REG_WIDTH, 2},
		'{ROW_CFG, REG_NONE, 4095},
		'{ROW_WEIGHT, 0, 4096},
		'{ROW_WEIGHT, 0, 8192},
		'{ROW_WEIGHT, 0, -8192},
		'{ROW_WEIGHT, 0, -16384}
	};

	// main sequence
	initial begin : main_seq
		int phase, kernels;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		fail_count = 0;
		hold_req   = 0;
		no_gaps    = 0;
		took       = 0;
		load_cnt   = 0;
		kw = 3;
		kh = 3;
		tol = 4;
		foreach (kern_mem[i]) kern_mem[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CFG) begin
				wait_drained();
				write_reg(directed[k].idx, directed[k].val);
			end else begin
				send_weight(directed[k].val, directed[k].kind == ROW_WEIGHT_1X1);
			end
		end
		wait_drained();

		// random phases
		phase = 0;
		while (weights_sent < ITEM_TARGET) begin
			wait_drained();
			if ($urandom_range(0, 3) != 0) begin
				write_reg(skf_pkg::REG_WIDTH, rand_dim());
				write_reg(skf_pkg::REG_HEIGHT, rand_dim());
			end
			case ($urandom_range(0, 5))
				0: write_reg(skf_pkg::REG_TOL, 0);
				1: write_reg(skf_pkg::REG_TOL, 4095);
				2: write_reg(skf_pkg::REG_TOL, $urandom_range(0, 4095));
				default: write_reg(skf_pkg::REG_TOL, $urandom_range(0, 64));
			endcase
			no_gaps = (phase % 5 == 3);
			// long receiver hold-off while kernels keep loading
			if (phase == 2) begin
				write_reg(skf_pkg::REG_WIDTH, 2);
				write_reg(skf_pkg::REG_HEIGHT, 2);
				hold_req = 400;
			end
			kernels = (phase == 2) ? 6 : $urandom_range(1, 3);
			repeat (kernels) send_random_kernel();
			phase++;
			while (weight_q.size() != 0 || sending) @(negedge clk);
		end
		wait_drained();

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
